// ===== sv/tgst_pkg.sv =====
// tgst_pkg: shared types and constants for the two-gate speed trap
// no dependencies; imported by two_gate_speed_trap and its checker
`timescale 1ns / 1ps

package tgst_pkg;

  // default width of the timestamp arithmetic
  localparam int TIME_BITS_DEF = 32;

  // port field widths
  localparam int NOW_W   = 32;
  localparam int DIST_W  = 16;
  localparam int DEB_W   = 20;
  localparam int TOUT_W  = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;
  localparam int SPEED_W = 24;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 32;

  // register reset values
  localparam logic [DIST_W-1:0] DIST_RST = DIST_W'(500);
  localparam logic [DEB_W-1:0]  DEB_RST  = DEB_W'(5000);
  localparam logic [TOUT_W-1:0] TOUT_RST = TOUT_W'(2000000);

  // 0.01 km/h per (mm/us): 3.6 * 1e6 * 100 / 1e3
  localparam int CENTI_PER_MM_US = 360000;
  // dividend width: 16-bit distance times a 19-bit constant
  localparam int NUM_W = 35;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_DIST     = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_DEBOUNCE = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_TIMEOUT  = IDX_W'(2);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== sv/two_gate_speed_trap.sv =====
// Timing: an item is taken only when the block is idle. A step that leaves no
// finished measurement shows its result in the cycle after the transfer; a
// step with both gates captured goes through a multiply state and then a
// restoring divider that forms the speed one quotient bit per cycle, after
// which the result waits in the output register until taken. The block takes
// no new item before the last result is taken: tready stays low from the
// input transfer until the result transfer.
//
// two_gate_speed_trap: debounced two-gate timer with speed computation
// depends on tgst_pkg
`timescale 1ns / 1ps

module two_gate_speed_trap #(
  parameter int TIME_BITS = tgst_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_wen,
  input  logic [tgst_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tgst_pkg::CFG_W-1:0]    cfg_data,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // now_us[31:0], fall_a[32], fall_b[33], clear_req[34], zero fill
  input  logic [tgst_pkg::S_DATA_W-1:0] s_axis_tdata,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // speed_ready[0], speed_centi_kmh[24:1], armed[25], timed_out[26], zero fill
  output logic [tgst_pkg::M_DATA_W-1:0] m_axis_tdata
);

  import tgst_pkg::*;

  localparam int T  = TIME_BITS;
  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  // configuration registers
  logic [DIST_W-1:0] gate_dist;
  logic [DEB_W-1:0]  debounce;
  logic [TOUT_W-1:0] timeout;

  // measurement state
  logic         armed_flag, captured_flag;
  logic [T-1:0] start_time, end_time, last_a, last_b;
  logic         armed_flag_next, captured_flag_next;
  logic [T-1:0] start_time_next, end_time_next, last_a_next, last_b_next;
  logic         tout_next;

  // sequencer and datapath
  state_t           state, state_next;
  logic [NUM_W-1:0] num;
  logic [T-1:0]     rem, dt;
  logic [CNT_W-1:0] cnt;
  logic             res_ready, res_armed, res_tout;
  logic [SPEED_W-1:0] res_speed;

  // input unpacking
  logic [T-1:0] now_t;
  logic         fa, fb, clr;
  logic [T-1:0] el_a, el_b, el_s;
  logic         take;

  // divider step
  logic [T:0]   rem_sh;
  logic         qbit;

  assign now_t = T'(s_axis_tdata[NOW_W-1:0]);
  assign fa    = s_axis_tdata[NOW_W];
  assign fb    = s_axis_tdata[NOW_W+1];
  assign clr   = s_axis_tdata[NOW_W+2];
  assign take  = s_axis_tvalid && s_axis_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_dist <= DIST_RST;
      debounce  <= DEB_RST;
      timeout   <= TOUT_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_DIST:     gate_dist <= cfg_data[DIST_W-1:0];
        REG_DEBOUNCE: debounce  <= cfg_data[DEB_W-1:0];
        REG_TIMEOUT:  timeout   <= cfg_data[TOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // one step: clear, edge a, edge b, timeout
  always_comb begin
    armed_flag_next    = armed_flag;
    captured_flag_next = captured_flag;
    start_time_next    = start_time;
    end_time_next      = end_time;
    last_a_next        = last_a;
    last_b_next        = last_b;
    tout_next          = 1'b0;
    el_a = now_t - last_a;
    el_b = now_t - last_b;
    if (clr) begin
      armed_flag_next    = 1'b0;
      captured_flag_next = 1'b0;
      start_time_next    = '0;
      end_time_next      = '0;
    end
    if (fa && (CW'(el_a) >= CW'(debounce))) begin
      last_a_next = now_t;
      if (!armed_flag_next) begin
        start_time_next = now_t;
        armed_flag_next = 1'b1;
      end
    end
    if (fb && (CW'(el_b) >= CW'(debounce))) begin
      last_b_next = now_t;
      if (armed_flag_next && !captured_flag_next) begin
        end_time_next      = now_t;
        captured_flag_next = 1'b1;
      end
    end
    el_s = now_t - start_time_next;
    if (armed_flag_next && !captured_flag_next && (CW'(el_s) > CW'(timeout))) begin
      armed_flag_next    = 1'b0;
      captured_flag_next = 1'b0;
      start_time_next    = '0;
      end_time_next      = '0;
      tout_next          = 1'b1;
    end
  end

  // state update on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag    <= 1'b0;
      captured_flag <= 1'b0;
      start_time    <= '0;
      end_time      <= '0;
      last_a        <= '0;
      last_b        <= '0;
    end else if (take) begin
      armed_flag    <= armed_flag_next;
      captured_flag <= captured_flag_next;
      start_time    <= start_time_next;
      end_time      <= end_time_next;
      last_a        <= last_a_next;
      last_b        <= last_b_next;
    end
  end

  // restoring divider step: one quotient bit per cycle
  assign rem_sh = {rem, num[NUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dt});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take) state_next = (armed_flag_next && captured_flag_next) ? ST_MUL : ST_OUT;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (cnt == '0) state_next = ST_OUT;
      ST_OUT:  if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE) && !rst;
    m_axis_tvalid = (state == ST_OUT);
  end

  // datapath: capture flags, multiply, divide, saturate
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (take) begin
          res_ready <= armed_flag_next && captured_flag_next;
          res_armed <= armed_flag_next;
          res_tout  <= tout_next;
          res_speed <= '0;
        end
      end
      ST_MUL: begin
        num <= NUM_W'(gate_dist) * NUM_W'(CENTI_PER_MM_US);
        rem <= '0;
        cnt <= CNT_W'(NUM_W - 1);
        dt  <= end_time - start_time;
        // end at or before start: quotient forced to zero below
        if (end_time <= start_time) res_ready <= 1'b1;
      end
      ST_DIV: begin
        rem <= qbit ? T'(rem_sh - {1'b0, dt}) : rem_sh[T-1:0];
        num <= {num[NUM_W-2:0], qbit};
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          if (end_time <= start_time)
            res_speed <= '0;
          else if (|num[NUM_W-2:SPEED_W-1])
            res_speed <= SPEED_MAX;
          else
            res_speed <= {num[SPEED_W-2:0], qbit};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {(M_DATA_W - SPEED_W - 3)'(0), res_tout, res_armed, res_speed, res_ready};

endmodule

// ===== sv/tgst_checker.sv =====
// tgst_checker: port-level checks for two_gate_speed_trap, bound to the top level
// depends on tgst_pkg
`timescale 1ns / 1ps

module tgst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tgst_pkg::M_DATA_W-1:0] m_axis_tdata
);

  import tgst_pkg::*;

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // no new item while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input ready while result pending");

  // after an input transfer the block is busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after input transfer");

  // speed is zero unless a measurement is ready
  a_speed_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[SPEED_W:1] == '0)
    else $error("speed without ready");

  // a timeout leaves nothing armed or ready
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[SPEED_W+2] |-> !m_axis_tdata[SPEED_W+1] && !m_axis_tdata[0])
    else $error("timeout with armed or ready set");

endmodule

bind two_gate_speed_trap tgst_checker u_tgst_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/two_gate_speed_trap_tb.sv =====
`timescale 1ns / 1ps
// two_gate_speed_trap_tb: self-checking bench for the two-gate speed trap,
// with an in-bench predictor, random idling on both streams and a watchdog
// depends on tgst_pkg and two_gate_speed_trap

module two_gate_speed_trap_tb;
  import tgst_pkg::*;

  localparam int ITEM_TARGET   = 1950;
  localparam int RANDOM_PHASES = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 40;
  localparam int REPORT_CAP    = 40;
  localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(3);

  // one gate sample, now_us in the low bits as on the input stream
  typedef struct packed {
    logic             clear_req;
    logic             fall_b;
    logic             fall_a;
    logic [NOW_W-1:0] now_us;
  } gate_event_t;

  // one reading, speed_ready in bit 0 as on the result stream
  typedef struct packed {
    logic               timed_out;
    logic               armed;
    logic [SPEED_W-1:0] speed_centi_kmh;
    logic               speed_ready;
  } trap_reading_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                cfg_wen       = 1'b0;
  logic [IDX_W-1:0]    cfg_index     = '0;
  logic [CFG_W-1:0]    cfg_data      = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  // predictor copy of registers and measurement state
  logic [DIST_W-1:0] dist_mm;
  logic [DEB_W-1:0]  debounce_us;
  logic [TOUT_W-1:0] timeout_us;
  logic              trap_armed;
  logic              trap_captured;
  logic [NOW_W-1:0]  start_us;
  logic [NOW_W-1:0]  end_us;
  logic [NOW_W-1:0]  last_a_us;
  logic [NOW_W-1:0]  last_b_us;

  trap_reading_t expected_readings[$];

  logic             src_gaps      = 1'b1;
  logic             sink_gaps     = 1'b1;
  logic             hold_request  = 1'b0;
  int               hold_left     = 0;
  logic [NOW_W-1:0] sim_clock_us  = '0;
  int               events_sent   = 0;
  int               settings_made = 0;
  int               mismatches    = 0;
  int               n_readings    = 0;
  int               n_ready       = 0;
  int               n_saturated   = 0;
  int               n_timeouts    = 0;
  int               quiet_cycles  = 0;

  two_gate_speed_trap u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // abandon the current measurement, edge history stays
  function automatic void drop_measurement();
    trap_armed    = 1'b0;
    trap_captured = 1'b0;
    start_us      = '0;
    end_us        = '0;
  endfunction

  // advance the trap state by one sample and form its reading
  function automatic trap_reading_t predict_reading(input gate_event_t ev);
    trap_reading_t    r;
    logic [NOW_W-1:0] since;
    logic [63:0]      quotient;
    r = '0;
    if (ev.clear_req) drop_measurement();
    since = ev.now_us - last_a_us;
    if (ev.fall_a && since >= NOW_W'(debounce_us)) begin
      last_a_us = ev.now_us;
      if (!trap_armed) begin
        start_us   = ev.now_us;
        trap_armed = 1'b1;
      end
    end
    since = ev.now_us - last_b_us;
    if (ev.fall_b && since >= NOW_W'(debounce_us)) begin
      last_b_us = ev.now_us;
      if (trap_armed && !trap_captured) begin
        end_us        = ev.now_us;
        trap_captured = 1'b1;
      end
    end
    since = ev.now_us - start_us;
    if (trap_armed && !trap_captured && since > timeout_us) begin
      drop_measurement();
      r.timed_out = 1'b1;
    end
    r.armed       = trap_armed;
    r.speed_ready = trap_armed && trap_captured;
    // transit time that runs backwards or is zero reads as speed 0
    if (r.speed_ready && end_us > start_us) begin
      quotient = (64'(dist_mm) * 64'(CENTI_PER_MM_US)) / 64'(end_us - start_us);
      r.speed_centi_kmh = (quotient > 64'(SPEED_MAX)) ? SPEED_MAX : quotient[SPEED_W-1:0];
    end
    return r;
  endfunction

  // time step between samples, biased toward debounce and timeout borders
  function automatic logic [NOW_W-1:0] next_gap();
    case ($urandom_range(9))
      0: return NOW_W'($urandom_range(3));
      1: return NOW_W'($urandom_range(debounce_us));
      2: return NOW_W'(debounce_us);
      3: return timeout_us + NOW_W'($urandom_range(2)) - NOW_W'(1);
      4: return NOW_W'($urandom);
      default: return NOW_W'(debounce_us) + NOW_W'($urandom_range(300000));
    endcase
  endfunction

  // offer one sample, predict it at its transfer
  task automatic send_event(input logic [NOW_W-1:0] now, input logic fa,
                            input logic fb, input logic clr);
    gate_event_t ev;
    ev = '{clear_req: clr, fall_b: fb, fall_a: fa, now_us: now};
    @(negedge clk);
    if (src_gaps && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      do begin
        @(negedge clk);
      end while ($urandom_range(99) < 23);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'(ev);
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    expected_readings.push_back(predict_reading(ev));
    events_sent++;
  endtask

  // stop offering and wait until every reading is back
  task automatic wait_for_drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // one register write, only while the block is idle
  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_DIST:     dist_mm     = value[DIST_W-1:0];
      REG_DEBOUNCE: debounce_us = value[DEB_W-1:0];
      REG_TIMEOUT:  timeout_us  = value[TOUT_W-1:0];
      default: ;
    endcase
    settings_made++;
  endtask

  // arming, capture, repeats, clear and timeout border at reset settings
  task automatic test_gate_sequencing();
    send_event(32'd100, 1'b1, 1'b0, 1'b0);
    send_event(32'd200, 1'b0, 1'b1, 1'b0);
    send_event(32'd10000, 1'b1, 1'b0, 1'b0);
    send_event(32'd16000, 1'b1, 1'b0, 1'b0);
    send_event(32'd20000, 1'b0, 1'b1, 1'b0);
    send_event(32'd30000, 1'b0, 1'b1, 1'b0);
    send_event(32'd40000, 1'b0, 1'b0, 1'b1);
    send_event(32'd50000, 1'b0, 1'b1, 1'b0);
    send_event(32'd60000, 1'b1, 1'b0, 1'b0);
    send_event(32'd2060000, 1'b0, 1'b0, 1'b0);
    send_event(32'd2060001, 1'b0, 1'b0, 1'b0);
    send_event(32'd3000000, 1'b1, 1'b1, 1'b0);
    send_event(32'd3100000, 1'b1, 1'b0, 1'b1);
    send_event(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
    send_event(32'd0, 1'b0, 1'b0, 1'b1);
  endtask

  // register extremes: saturation, zero distance, zero timeout, wrap, wide debounce
  task automatic test_register_extremes();
    wait_for_drain();
    write_register(REG_DIST, 32'hA5A5_FFFF);
    write_register(REG_DEBOUNCE, 32'd0);
    write_register(REG_TIMEOUT, 32'hFFFF_FFFF);
    send_event(32'h0000_1000, 1'b1, 1'b0, 1'b0);
    send_event(32'h0000_1001, 1'b0, 1'b1, 1'b0);
    send_event(32'h0000_1002, 1'b0, 1'b0, 1'b1);
    wait_for_drain();
    write_register(REG_DIST, 32'd0);
    write_register(REG_SPARE, 32'h0000_1234);
    send_event(32'h0000_2000, 1'b1, 1'b0, 1'b0);
    send_event(32'h0000_2005, 1'b0, 1'b1, 1'b0);
    wait_for_drain();
    write_register(REG_TIMEOUT, 32'd0);
    write_register(REG_DIST, 32'd1234);
    send_event(32'h0000_3000, 1'b1, 1'b0, 1'b1);
    send_event(32'h0000_3001, 1'b0, 1'b0, 1'b0);
    wait_for_drain();
    write_register(REG_TIMEOUT, 32'hFFFF_FFFF);
    send_event(32'hFFFF_FF00, 1'b1, 1'b0, 1'b0);
    send_event(32'h0000_0010, 1'b0, 1'b1, 1'b0);
    send_event(32'h0000_0020, 1'b0, 1'b0, 1'b1);
    wait_for_drain();
    // upper bits beyond the register width are dropped
    write_register(REG_DEBOUNCE, 32'hFFFF_FFFF);
    send_event(32'h0000_0030, 1'b1, 1'b0, 1'b0);
    send_event(32'h0010_0000, 1'b1, 1'b0, 1'b0);
    send_event(32'h0010_0001, 1'b0, 1'b1, 1'b0);
  endtask

  // receiver holds off while samples keep coming, then sender waits for all readings
  task automatic test_backpressure();
    int k;
    wait_for_drain();
    write_register(REG_DIST, 32'd500);
    write_register(REG_DEBOUNCE, 32'd5000);
    write_register(REG_TIMEOUT, 32'd2000000);
    src_gaps     = 1'b0;
    hold_request = 1'b1;
    for (k = 0; k < 8; k++) begin
      sim_clock_us += next_gap();
      send_event(sim_clock_us, (k % 2) == 0, (k % 2) == 1, 1'b0);
    end
    wait_for_drain();
    src_gaps = 1'b1;
  endtask

  // new random settings, extremes weighted in, stray upper bits on the bus
  task automatic pick_settings();
    logic [DIST_W-1:0] dist_pick;
    logic [DEB_W-1:0]  deb_pick;
    logic [TOUT_W-1:0] tout_pick;
    logic [CFG_W-1:0]  junk;
    case ($urandom_range(5))
      0: dist_pick = DIST_W'(1);
      1: dist_pick = '1;
      2: dist_pick = DIST_W'($urandom_range(1, 65535));
      default: dist_pick = DIST_W'($urandom_range(200, 3000));
    endcase
    case ($urandom_range(5))
      0: deb_pick = '0;
      1: deb_pick = DEB_W'(1000000);
      2: deb_pick = DEB_W'($urandom);
      default: deb_pick = DEB_W'($urandom_range(0, 20000));
    endcase
    case ($urandom_range(7))
      0: tout_pick = '0;
      1: tout_pick = '1;
      2: tout_pick = $urandom;
      default: tout_pick = TOUT_W'($urandom_range(1000, 3000000));
    endcase
    junk = $urandom;
    write_register(REG_DIST, {junk[CFG_W-1:DIST_W], dist_pick});
    write_register(REG_DEBOUNCE, {junk[CFG_W-1:DEB_W], deb_pick});
    write_register(REG_TIMEOUT, tout_pick);
  endtask

  // a car pass: A edge, maybe bounces or idle samples, B edge, lingering samples
  task automatic run_pass();
    int k;
    sim_clock_us += next_gap();
    send_event(sim_clock_us, 1'b1, $urandom_range(7) == 0, $urandom_range(7) == 0);
    for (k = $urandom_range(3); k > 0; k--) begin
      sim_clock_us += next_gap();
      send_event(sim_clock_us, $urandom_range(3) == 0, $urandom_range(5) == 0, 1'b0);
    end
    sim_clock_us += next_gap();
    send_event(sim_clock_us, 1'b0, 1'b1, 1'b0);
    for (k = $urandom_range(2); k > 0; k--) begin
      sim_clock_us += next_gap();
      send_event(sim_clock_us, 1'b0, 1'b0, $urandom_range(2) == 0);
    end
  endtask

  // stray sample with random flags, sometimes a jump in time or toward the wrap
  task automatic run_noise();
    case ($urandom_range(5))
      0: sim_clock_us = $urandom;
      1: sim_clock_us = 32'hFFFF_FFFF - NOW_W'($urandom_range(400000));
      default: sim_clock_us += next_gap();
    endcase
    send_event(sim_clock_us, 1'($urandom_range(1)), 1'($urandom_range(1)),
               $urandom_range(7) == 0);
  endtask

  // random phases, each under fresh settings; phase 1 runs without idling
  task automatic test_random_traffic();
    int phase;
    int phase_stop;
    sim_clock_us = $urandom;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_drain();
      pick_settings();
      src_gaps   = (phase != 1);
      sink_gaps  = (phase != 1);
      phase_stop = events_sent + (ITEM_TARGET - events_sent) / (RANDOM_PHASES - phase);
      while (events_sent < phase_stop) begin
        if ($urandom_range(9) < 7) run_pass();
        else run_noise();
      end
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // result receiver: random idling plus long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_gaps) begin
      m_axis_tready <= ($urandom_range(99) >= 23);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // check each result transfer against the oldest prediction
  always @(posedge clk) begin
    trap_reading_t got;
    trap_reading_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = trap_reading_t'(m_axis_tdata[$bits(trap_reading_t)-1:0]);
      if (expected_readings.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected reading, expected none actual %h", $time, m_axis_tdata);
      end else begin
        want = expected_readings.pop_front();
        compare_field("speed_ready", want.speed_ready, got.speed_ready);
        compare_field("speed_centi_kmh", want.speed_centi_kmh, got.speed_centi_kmh);
        compare_field("armed", want.armed, got.armed);
        compare_field("timed_out", want.timed_out, got.timed_out);
        n_readings++;
        if (want.speed_ready) n_ready++;
        if (want.speed_centi_kmh == SPEED_MAX) n_saturated++;
        if (want.timed_out) n_timeouts++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("two_gate_speed_trap verification failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    dist_mm     = DIST_RST;
    debounce_us = DEB_RST;
    timeout_us  = TOUT_RST;
    last_a_us   = '0;
    last_b_us   = '0;
    drop_measurement();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_gate_sequencing();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d gate samples under %0d register writes", events_sent, settings_made);
    $display("readings %0d: %0d with speed, %0d saturated, %0d timeouts",
             n_readings, n_ready, n_saturated, n_timeouts);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("two_gate_speed_trap verification clean");
    end else begin
      $display("two_gate_speed_trap verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tgst_pkg.sv
sv/two_gate_speed_trap.sv
sv/tgst_checker.sv
bench/two_gate_speed_trap_tb.sv
